// ===== rtl/core/dfas_pkg.sv =====
// Shared types, constants and digit functions of the decimal float adder.
package dfas_pkg;

   localparam int MANT_DIGITS  = 24;
   localparam int EXP_BITS     = 10;
   localparam int FIELD_DIGITS = 24;
   localparam int DIGIT_BITS   = 4;
   localparam int HALF_BITS    = 48;
   localparam int FIELD_BITS   = FIELD_DIGITS * DIGIT_BITS;
   localparam int MANT_BITS    = MANT_DIGITS * DIGIT_BITS;
   localparam int WIDE_DIGITS  = MANT_DIGITS + 1;
   localparam int WIDE_BITS    = WIDE_DIGITS * DIGIT_BITS;
   localparam int PAD_BITS     = FIELD_BITS - MANT_BITS;
   localparam int EXPW         = EXP_BITS + 2;
   localparam int GAP_BITS     = EXP_BITS + 1;
   localparam int CNT_BITS     = $clog2(WIDE_DIGITS + 1);

   localparam logic [3:0] DIGIT_MAX = 4'd9;
   localparam logic [4:0] RADIX     = 5'd10;
   localparam logic [4:0] RADIX2    = 5'd20;
   localparam logic [3:0] NEG_GUARD = 4'd5;

   typedef logic [DIGIT_BITS-1:0] digit_type;
   typedef logic [MANT_BITS-1:0]  mant_type;
   typedef logic [WIDE_BITS-1:0]  wide_type;
   typedef logic signed [EXPW-1:0] exp_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;

   // Digit ALU operations
   typedef logic [2:0] alu_op_type;
   localparam alu_op_type ALU_HOLD  = 3'd0;
   localparam alu_op_type ALU_LOAD  = 3'd1;
   localparam alu_op_type ALU_ALIGN = 3'd2;
   localparam alu_op_type ALU_ADD   = 3'd3;
   localparam alu_op_type ALU_PREP  = 3'd4;
   localparam alu_op_type ALU_COMP  = 3'd5;

   // Normaliser operations
   typedef logic [1:0] nrm_op_type;
   localparam nrm_op_type NRM_HOLD  = 2'd0;
   localparam nrm_op_type NRM_EXP   = 2'd1;
   localparam nrm_op_type NRM_LOAD  = 2'd2;
   localparam nrm_op_type NRM_SHIFT = 2'd3;

   typedef struct packed {
      mant_type first_mant;
      mant_type second_mant;
      logic     first_neg;
      logic     sub;
      exp_type  big_exp;
      cnt_type  gap_cnt;
   } op_type;

   typedef struct packed {
      nrm_op_type op;
      logic       neg;
   } nrm_ctrl_type;

   typedef struct packed {
      logic done;
      logic zero;
   } nrm_stat_type;

   // Nibbles above nine read as nine
   function automatic mant_type cap_digits(input mant_type m);
      mant_type  r;
      digit_type nib;
      for (int i = 0; i < MANT_DIGITS; i++) begin
         nib = m[i*DIGIT_BITS +: DIGIT_BITS];
         r[i*DIGIT_BITS +: DIGIT_BITS] = (nib > DIGIT_MAX) ? DIGIT_MAX : nib;
      end
      return r;
   endfunction

   // One decimal digit step: optional nines' complement of either operand,
   // carry in 0..2. Returns {carry, digit}.
   function automatic logic [5:0] digit_add(input digit_type f, input logic inv_f,
                                             input digit_type s, input logic inv_s,
                                             input logic [1:0] cin);
      logic [4:0] fv;
      logic [4:0] sv;
      logic [4:0] t;
      logic [4:0] d;
      logic [1:0] c;
      fv = inv_f ? ({1'b0, DIGIT_MAX} - {1'b0, f}) : {1'b0, f};
      sv = inv_s ? ({1'b0, DIGIT_MAX} - {1'b0, s}) : {1'b0, s};
      t  = fv + sv + {3'b000, cin};
      if (t >= RADIX2) begin
         d = t - RADIX2;
         c = 2'd2;
      end else if (t >= RADIX) begin
         d = t - RADIX;
         c = 2'd1;
      end else begin
         d = t;
         c = 2'd0;
      end
      return {c, d[3:0]};
   endfunction

endpackage

// ===== rtl/core/dfas_unpack.sv =====
// Operand unpacking: digit capping, operand ordering by exponent, alignment gap.
module dfas_unpack (
   input  logic [dfas_pkg::HALF_BITS-1:0]       a_mant_hi,
   input  logic [dfas_pkg::HALF_BITS-1:0]       a_mant_lo,
   input  logic signed [dfas_pkg::EXP_BITS-1:0] a_exp,
   input  logic                                 a_neg,
   input  logic [dfas_pkg::HALF_BITS-1:0]       b_mant_hi,
   input  logic [dfas_pkg::HALF_BITS-1:0]       b_mant_lo,
   input  logic signed [dfas_pkg::EXP_BITS-1:0] b_exp,
   input  logic                                 b_neg,
   input  logic                                 subtract,
   output dfas_pkg::op_type                     op
);

   logic [dfas_pkg::FIELD_BITS-1:0] a_full;
   logic [dfas_pkg::FIELD_BITS-1:0] b_full;
   dfas_pkg::mant_type              a_mant;
   dfas_pkg::mant_type              b_mant;
   logic [dfas_pkg::GAP_BITS-1:0]   diff;
   logic [dfas_pkg::GAP_BITS-1:0]   gap;
   logic                            a_first;
   logic                            b_sign;
   logic                            big_gap;
   dfas_pkg::exp_type               ea;
   dfas_pkg::exp_type               eb;

   assign a_full = {a_mant_hi, a_mant_lo};
   assign b_full = {b_mant_hi, b_mant_lo};
   // leading digits only when the mantissa is shorter than the field
   assign a_mant = dfas_pkg::cap_digits(dfas_pkg::MANT_BITS'(a_full >> dfas_pkg::PAD_BITS));
   assign b_mant = dfas_pkg::cap_digits(dfas_pkg::MANT_BITS'(b_full >> dfas_pkg::PAD_BITS));

   assign ea = {{2{a_exp[dfas_pkg::EXP_BITS-1]}}, a_exp};
   assign eb = {{2{b_exp[dfas_pkg::EXP_BITS-1]}}, b_exp};

   assign diff    = {a_exp[dfas_pkg::EXP_BITS-1], a_exp} - {b_exp[dfas_pkg::EXP_BITS-1], b_exp};
   assign a_first = ~diff[dfas_pkg::GAP_BITS-1];   // equal exponents keep a first
   assign gap     = a_first ? diff : (~diff + 1'b1);
   assign big_gap = gap >= dfas_pkg::GAP_BITS'(dfas_pkg::MANT_DIGITS);
   assign b_sign  = b_neg ^ subtract;

   always_comb begin
      op.first_mant  = a_first ? a_mant : b_mant;
      op.second_mant = big_gap ? '0 : (a_first ? b_mant : a_mant);
      op.first_neg   = a_first ? a_neg : b_sign;
      op.sub         = a_first ? b_sign : a_neg;
      op.big_exp     = a_first ? ea : eb;
      op.gap_cnt     = big_gap ? '0 : dfas_pkg::CNT_BITS'(gap);
   end

endmodule

// ===== rtl/core/dfas_digit_alu.sv =====
// Digit-serial ten's complement adder: align shifter, add pass, complement pass.
module dfas_digit_alu (
   input  logic                   clock,
   input  dfas_pkg::alu_op_type   alu_op,
   input  dfas_pkg::op_type       op,
   output dfas_pkg::wide_type     sum,
   output dfas_pkg::digit_type    guard
);

   dfas_pkg::wide_type f_ff, f_in;
   dfas_pkg::wide_type s_ff, s_in;
   dfas_pkg::wide_type r_ff, r_in;
   logic [1:0]         c_ff, c_in;
   logic               fneg_ff, fneg_in;
   logic               sub_ff, sub_in;
   logic               comp;
   logic [5:0]         step;

   assign comp = (alu_op == dfas_pkg::ALU_COMP);
   // complement pass reuses the adder with the result fed back and no addend
   assign step = dfas_pkg::digit_add(comp ? r_ff[3:0] : f_ff[3:0], comp | fneg_ff,
                                     comp ? 4'd0 : s_ff[3:0], ~comp & sub_ff, c_ff);

   always_comb begin
      f_in    = f_ff;
      s_in    = s_ff;
      r_in    = r_ff;
      c_in    = c_ff;
      fneg_in = fneg_ff;
      sub_in  = sub_ff;
      case (alu_op)
         dfas_pkg::ALU_LOAD: begin
            f_in    = dfas_pkg::WIDE_BITS'(op.first_mant);
            s_in    = dfas_pkg::WIDE_BITS'(op.second_mant);
            c_in    = {1'b0, op.first_neg} + {1'b0, op.sub};
            fneg_in = op.first_neg;
            sub_in  = op.sub;
         end
         dfas_pkg::ALU_ALIGN: begin
            s_in = s_ff >> dfas_pkg::DIGIT_BITS;
         end
         dfas_pkg::ALU_ADD: begin
            f_in = f_ff >> dfas_pkg::DIGIT_BITS;
            s_in = s_ff >> dfas_pkg::DIGIT_BITS;
            r_in = {step[3:0], r_ff[dfas_pkg::WIDE_BITS-1:dfas_pkg::DIGIT_BITS]};
            c_in = step[5:4];
         end
         dfas_pkg::ALU_PREP: begin
            c_in = 2'd1;
         end
         dfas_pkg::ALU_COMP: begin
            r_in = {step[3:0], r_ff[dfas_pkg::WIDE_BITS-1:dfas_pkg::DIGIT_BITS]};
            c_in = step[5:4];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      f_ff    <= f_in;
      s_ff    <= s_in;
      r_ff    <= r_in;
      c_ff    <= c_in;
      fneg_ff <= fneg_in;
      sub_ff  <= sub_in;
   end

   assign sum   = r_ff;
   assign guard = r_ff[dfas_pkg::WIDE_BITS-1 -: dfas_pkg::DIGIT_BITS];

endmodule

// ===== rtl/core/dfas_normalize.sv =====
// Carry-out fix-up and leading-zero normaliser, one digit per cycle.
module dfas_normalize (
   input  logic                                 clock,
   input  dfas_pkg::nrm_ctrl_type               ctrl,
   input  dfas_pkg::exp_type                    exp_base,
   input  dfas_pkg::wide_type                   sum,
   output dfas_pkg::mant_type                   mant,
   output logic signed [dfas_pkg::EXP_BITS-1:0] res_exp,
   output logic                                 res_neg,
   output logic                                 exp_overflow,
   output dfas_pkg::nrm_stat_type               stat
);

   dfas_pkg::mant_type m_ff, m_in;
   dfas_pkg::exp_type  e_ff, e_in;
   logic               neg_ff, neg_in;
   dfas_pkg::cnt_type  cnt_ff, cnt_in;
   logic               top_zero;
   logic [2:0]         e_top;

   assign top_zero  = (m_ff[dfas_pkg::MANT_BITS-1 -: dfas_pkg::DIGIT_BITS] == '0);
   assign stat.zero = (cnt_ff == dfas_pkg::CNT_BITS'(dfas_pkg::MANT_DIGITS));
   assign stat.done = ~top_zero | stat.zero;

   always_comb begin
      m_in   = m_ff;
      e_in   = e_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      case (ctrl.op)
         dfas_pkg::NRM_EXP: begin
            e_in = exp_base;
         end
         dfas_pkg::NRM_LOAD: begin
            neg_in = ctrl.neg;
            cnt_in = '0;
            if (sum[dfas_pkg::WIDE_BITS-1 -: dfas_pkg::DIGIT_BITS] != '0) begin
               // carry into guard: drop last digit, bump exponent
               m_in = sum[dfas_pkg::WIDE_BITS-1:dfas_pkg::DIGIT_BITS];
               e_in = e_ff + dfas_pkg::EXPW'(1);
            end else begin
               m_in = sum[dfas_pkg::MANT_BITS-1:0];
            end
         end
         dfas_pkg::NRM_SHIFT: begin
            if (!stat.done) begin
               m_in   = m_ff << dfas_pkg::DIGIT_BITS;
               e_in   = e_ff - dfas_pkg::EXPW'(1);
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff   <= m_in;
      e_ff   <= e_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign e_top        = e_ff[dfas_pkg::EXPW-1:dfas_pkg::EXP_BITS-1];
   assign mant         = m_ff;
   assign res_exp      = stat.zero ? '0 : e_ff[dfas_pkg::EXP_BITS-1:0];
   assign res_neg      = neg_ff & ~stat.zero;
   assign exp_overflow = ~stat.zero & (e_top != 3'b000) & (e_top != 3'b111);

endmodule

// ===== rtl/core/decimal_float_add_sub.sv =====
// Top level of the digit-serial decimal floating-point adder/subtractor.
//
// Request channel (req_*): two operands, each a 24-digit packed BCD mantissa
// (0.d1d2...), a signed exponent and a sign, plus subtract (a - b when set).
// A transaction is taken when req_valid is high and req_stall is low; the
// block works on one transaction at a time and holds req_stall high from the
// cycle after acceptance until its result has entered the output register.
// Response channel (rsp_*): normalised mantissa, exponent, sign and an
// exponent overflow flag, held in an output register until rsp_valid meets
// a low rsp_stall. A waiting result does not block the next request.
// After acceptance the second operand is shifted by the alignment gap (none
// when the gap reaches 24 digits or more, else the exponent difference), the
// operands are added, a negative ten's complement sum is complemented and the
// leading zeros are removed. The digit adder and the normaliser move one BCD
// digit per cycle; a new request may be taken once the result is registered.
// While rsp_stall holds a result, a finished transaction waits in its final
// state. Synchronous reset empties the output register and idles the block.
module decimal_float_add_sub (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dfas_pkg::HALF_BITS-1:0]       req_a_mant_hi,
   input  logic [dfas_pkg::HALF_BITS-1:0]       req_a_mant_lo,
   input  logic signed [dfas_pkg::EXP_BITS-1:0] req_a_exp,
   input  logic                                 req_a_neg,
   input  logic [dfas_pkg::HALF_BITS-1:0]       req_b_mant_hi,
   input  logic [dfas_pkg::HALF_BITS-1:0]       req_b_mant_lo,
   input  logic signed [dfas_pkg::EXP_BITS-1:0] req_b_exp,
   input  logic                                 req_b_neg,
   input  logic                                 req_subtract,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dfas_pkg::HALF_BITS-1:0]       rsp_res_mant_hi,
   output logic [dfas_pkg::HALF_BITS-1:0]       rsp_res_mant_lo,
   output logic signed [dfas_pkg::EXP_BITS-1:0] rsp_res_exp,
   output logic                                 rsp_res_neg,
   output logic                                 rsp_exp_overflow
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ALIGN = 3'd1;
   localparam logic [2:0] S_ADD   = 3'd2;
   localparam logic [2:0] S_SIGN  = 3'd3;
   localparam logic [2:0] S_COMP  = 3'd4;
   localparam logic [2:0] S_NLOAD = 3'd5;
   localparam logic [2:0] S_NORM  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]                       state_ff, state_in;
   dfas_pkg::cnt_type                cnt_ff, cnt_in;
   logic                             neg_ff, neg_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dfas_pkg::HALF_BITS-1:0]   mant_hi_ff, mant_lo_ff;
   logic [dfas_pkg::EXP_BITS-1:0]    exp_ff;
   logic                             rneg_ff, ovf_ff;

   dfas_pkg::op_type                 op;
   dfas_pkg::alu_op_type             alu_op;
   dfas_pkg::wide_type               sum;
   dfas_pkg::digit_type              guard;
   dfas_pkg::nrm_ctrl_type           nrm_ctrl;
   dfas_pkg::nrm_stat_type           nrm_stat;
   dfas_pkg::mant_type               nrm_mant;
   logic signed [dfas_pkg::EXP_BITS-1:0] nrm_exp;
   logic                             nrm_neg;
   logic                             nrm_ovf;
   logic [dfas_pkg::FIELD_BITS-1:0]  res_full;
   logic                             req_accept;
   logic                             out_free;
   logic                             out_load;

   dfas_unpack u_unpack (
      .a_mant_hi (req_a_mant_hi),
      .a_mant_lo (req_a_mant_lo),
      .a_exp     (req_a_exp),
      .a_neg     (req_a_neg),
      .b_mant_hi (req_b_mant_hi),
      .b_mant_lo (req_b_mant_lo),
      .b_exp     (req_b_exp),
      .b_neg     (req_b_neg),
      .subtract  (req_subtract),
      .op        (op)
   );

   dfas_digit_alu u_alu (
      .clock  (clock),
      .alu_op (alu_op),
      .op     (op),
      .sum    (sum),
      .guard  (guard)
   );

   dfas_normalize u_normalize (
      .clock        (clock),
      .ctrl         (nrm_ctrl),
      .exp_base     (op.big_exp),
      .sum          (sum),
      .mant         (nrm_mant),
      .res_exp      (nrm_exp),
      .res_neg      (nrm_neg),
      .exp_overflow (nrm_ovf),
      .stat         (nrm_stat)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid & ~req_stall;
   // output register takes a result when empty or being drained this cycle
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      alu_op       = dfas_pkg::ALU_HOLD;
      nrm_ctrl.op  = dfas_pkg::NRM_HOLD;
      nrm_ctrl.neg = neg_ff;
      out_load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               alu_op      = dfas_pkg::ALU_LOAD;
               nrm_ctrl.op = dfas_pkg::NRM_EXP;
               if (op.gap_cnt != '0) begin
                  state_in = S_ALIGN;
                  cnt_in   = op.gap_cnt;
               end else begin
                  state_in = S_ADD;
                  cnt_in   = dfas_pkg::CNT_BITS'(dfas_pkg::WIDE_DIGITS);
               end
            end
         end
         S_ALIGN: begin
            alu_op = dfas_pkg::ALU_ALIGN;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == dfas_pkg::CNT_BITS'(1)) begin
               state_in = S_ADD;
               cnt_in   = dfas_pkg::CNT_BITS'(dfas_pkg::WIDE_DIGITS);
            end
         end
         S_ADD: begin
            alu_op = dfas_pkg::ALU_ADD;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == dfas_pkg::CNT_BITS'(1)) begin
               state_in = S_SIGN;
            end
         end
         S_SIGN: begin
            // guard digit 5..9 marks a negative sum
            if (guard >= dfas_pkg::NEG_GUARD) begin
               neg_in   = 1'b1;
               alu_op   = dfas_pkg::ALU_PREP;
               cnt_in   = dfas_pkg::CNT_BITS'(dfas_pkg::WIDE_DIGITS);
               state_in = S_COMP;
            end else begin
               neg_in   = 1'b0;
               state_in = S_NLOAD;
            end
         end
         S_COMP: begin
            alu_op = dfas_pkg::ALU_COMP;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == dfas_pkg::CNT_BITS'(1)) begin
               state_in = S_NLOAD;
            end
         end
         S_NLOAD: begin
            nrm_ctrl.op = dfas_pkg::NRM_LOAD;
            state_in    = S_NORM;
         end
         S_NORM: begin
            if (nrm_stat.done) begin
               state_in = S_DONE;
            end else begin
               nrm_ctrl.op = dfas_pkg::NRM_SHIFT;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   // result digits sit at the top of the field, trailing digits zero
   assign res_full     = dfas_pkg::FIELD_BITS'(nrm_mant) << dfas_pkg::PAD_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         mant_hi_ff <= res_full[dfas_pkg::FIELD_BITS-1:dfas_pkg::HALF_BITS];
         mant_lo_ff <= res_full[dfas_pkg::HALF_BITS-1:0];
         exp_ff     <= nrm_exp;
         rneg_ff    <= nrm_neg;
         ovf_ff     <= nrm_ovf;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_res_mant_hi  = mant_hi_ff;
   assign rsp_res_mant_lo  = mant_lo_ff;
   assign rsp_res_exp      = exp_ff;
   assign rsp_res_neg      = rneg_ff;
   assign rsp_exp_overflow = ovf_ff;

endmodule

// ===== rtl/core/dfas_checker.sv =====
// Port-level checker for the decimal float adder, bound to the top level.
module dfas_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [dfas_pkg::HALF_BITS-1:0]       rsp_res_mant_hi,
   input logic [dfas_pkg::HALF_BITS-1:0]       rsp_res_mant_lo,
   input logic signed [dfas_pkg::EXP_BITS-1:0] rsp_res_exp,
   input logic                                 rsp_res_neg,
   input logic                                 rsp_exp_overflow
);

   // a held response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response dropped while stalled");

   // one transaction in flight: request side closes right after acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a transaction is in flight");

   // zero result carries a clean exponent and sign
   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_res_mant_hi == '0 && rsp_res_mant_lo == '0)
      |-> (rsp_res_exp == '0 && !rsp_res_neg && !rsp_exp_overflow))
      else $error("zero result with nonzero exponent, sign or overflow");

   // nonzero result is normalised
   a_normalised: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_res_mant_hi != '0 || rsp_res_mant_lo != '0))
      |-> (rsp_res_mant_hi[dfas_pkg::HALF_BITS-1 -: dfas_pkg::DIGIT_BITS] != '0))
      else $error("result has a leading zero digit");

endmodule

bind decimal_float_add_sub dfas_checker u_dfas_checker (.*);
